// File: src/mhpq_pkg.sv
`timescale 1ns / 1ps
package mhpq_pkg;
  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 32;
  localparam int NUM_IDS = 64;
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ID_W = 6;

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ID_W-1:0] id_t;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_POP = 2'd1;
  localparam logic [1:0] KIND_CHANGE = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_PRESENT = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_DECIDE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_RDR, S_DN_CMP,
    S_SWAP2, S_FIN_RD, S_FIN, S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0] status;
    logic has_item;
    logic [31:0] out_key;
    id_t out_id;
    cnt_t count;
  } result_t;
endpackage

// File: src/mhpq_if.sv
`timescale 1ns / 1ps
interface mhpq_in_if;
  import mhpq_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic signed [31:0] key_value;
  logic [5:0] item_id;
  modport source(output valid, kind, key_value, item_id, input ready);
  modport sink(input valid, kind, key_value, item_id, output ready);
endinterface

interface mhpq_out_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic has_item;
  logic signed [31:0] out_key;
  logic [5:0] out_id;
  logic [6:0] count;
  modport source(output valid, status, has_item, out_key, out_id, count, input ready);
  modport sink(input valid, status, has_item, out_key, out_id, count, output ready);
endinterface

// File: src/mhpq_cmp.sv
`timescale 1ns / 1ps
// shared key comparator
module mhpq_cmp
  import mhpq_pkg::*;
(
  input  key_t a,
  input  key_t b,
  output logic lt,
  output logic gt
);
  assign lt = a < b;
  assign gt = a > b;
endmodule

// File: src/min_heap_priority_queue.sv
`timescale 1ns / 1ps
// Each level moved up takes a parent read (S_UP_RD) and a compare (S_UP_CMP); each level
// moved down reads both children (S_DN_RD, S_DN_RDR) and then compares (S_DN_CMP), as set
// by the heap memory's single read port and the shared comparator. One item at a time:
// ready stays low from acceptance until the result has been taken.
// Reset (synchronous) clears count and presence bits; no clearing pass.
module min_heap_priority_queue
  import mhpq_pkg::*;
(
  input logic clk,
  input logic rst,
  mhpq_in_if.sink in_ch,
  mhpq_out_if.source out_ch
);
  // heap memory: key and id per slot
  key_t mem_k [CAPACITY];
  id_t  mem_i [CAPACITY];
  slot_t pos_of [NUM_IDS];
  logic [NUM_IDS-1:0] present;
  cnt_t cnt;

  state_t state, state_next;
  logic [1:0] kind;
  key_t key_in;
  id_t id_in;
  slot_t cur, rsl;
  key_t cur_k, lk;
  id_t cur_i, oth_i;
  logic [2:0] st;
  logic popped;
  key_t pop_k;
  id_t pop_i;
  result_t res;
  logic ovalid;
  slot_t pos_rd;

  // single read port
  slot_t raddr;
  key_t rk;
  id_t ri;
  // write port
  logic we;
  slot_t waddr;
  key_t wk;
  id_t wi;

  logic lt, gt;
  key_t ca, cb;
  logic dn_go;
  key_t smin;
  slot_t smin_s;
  mhpq_cmp u_cmp (.a(ca), .b(cb), .lt(lt), .gt(gt));

  cnt_t lc, rc;
  assign lc = {cur, 1'b1};
  assign rc = cnt_t'({cur, 1'b0}) + cnt_t'(2);

  always_ff @(posedge clk) begin
    if (we) begin
      mem_k[waddr] <= wk;
      mem_i[waddr] <= wi;
      pos_of[wi] <= waddr;
    end
    rk <= mem_k[raddr];
    ri <= mem_i[raddr];
    pos_rd <= pos_of[in_ch.item_id];
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = ovalid;
  assign out_ch.status = res.status;
  assign out_ch.has_item = res.has_item;
  assign out_ch.out_key = res.out_key;
  assign out_ch.out_id = res.out_id;
  assign out_ch.count = res.count;

  always_comb begin
    ca = rk;
    cb = cur_k;
    case (state)
      S_DECIDE: begin ca = key_in; cb = rk; end
      S_DN_CMP: begin ca = smin; cb = cur_k; end
      default: begin ca = rk; cb = cur_k; end
    endcase
  end

  always_comb begin
    if (rc < cnt && rk < lk) begin
      smin = rk; smin_s = slot_t'(rc);
    end else begin
      smin = lk; smin_s = slot_t'(lc);
    end
    dn_go = lt;
  end

  always_comb begin
    state_next = state;
    raddr = cur;
    we = 1'b0; waddr = cur; wk = cur_k; wi = cur_i;
    case (state)
      S_IDLE: if (in_ch.valid) state_next = S_RD0;
      S_RD0: begin
        raddr = cur;
        state_next = S_RD1;
      end
      S_RD1: begin
        state_next = S_DECIDE;
        if (kind == KIND_INSERT) begin
          if (present[id_in] || cnt >= cnt_t'(CAPACITY)) state_next = S_FIN_RD;
          else begin
            we = 1'b1; waddr = slot_t'(cnt); wk = key_in; wi = id_in;
            state_next = S_UP_RD;
          end
        end else if (kind == KIND_POP) begin
          if (cnt == '0) state_next = S_FIN_RD;
        end else if (kind == KIND_CHANGE) begin
          if (!present[id_in]) state_next = S_FIN_RD;
        end else state_next = S_FIN_RD;
        raddr = cur;
      end
      S_DECIDE: begin
        if (kind == KIND_POP) begin
          raddr = slot_t'(cnt - cnt_t'(1));
          state_next = S_SWAP2;
        end else begin
          we = 1'b1; waddr = cur; wk = key_in; wi = id_in;
          if (lt) state_next = S_UP_RD;
          else if (gt) state_next = S_DN_RD;
          else state_next = S_FIN_RD;
        end
      end
      S_SWAP2: begin
        // last entry read: place at root
        if (cnt == cnt_t'(1)) state_next = S_FIN_RD;
        else begin
          we = 1'b1; waddr = '0; wk = rk; wi = ri;
          state_next = S_DN_RD;
        end
      end
      S_UP_RD: begin
        raddr = (cur - slot_t'(1)) >> 1;
        // at the root: place the held entry
        we = (cur == '0);
        state_next = (cur == '0) ? S_FIN_RD : S_UP_CMP;
      end
      S_UP_CMP: begin
        if (gt) begin
          // parent greater: parent down, ours up
          we = 1'b1; waddr = cur; wk = rk; wi = ri;
          state_next = S_UP_RD;
        end else begin
          we = 1'b1; waddr = cur; wk = cur_k; wi = cur_i;
          state_next = S_FIN_RD;
        end
      end
      S_DN_RD: begin
        raddr = slot_t'(lc);
        state_next = (lc >= cnt) ? S_FIN_RD : S_DN_RDR;
        if (lc >= cnt) begin we = 1'b1; waddr = cur; wk = cur_k; wi = cur_i; end
      end
      S_DN_RDR: begin
        raddr = slot_t'(rc);
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1; waddr = cur;
        if (dn_go) begin
          wk = smin; wi = (smin_s == slot_t'(lc)) ? oth_i : ri;
          state_next = S_DN_RD;
        end else begin
          wk = cur_k; wi = cur_i;
          state_next = S_FIN_RD;
        end
      end
      S_FIN_RD: begin
        raddr = '0;
        state_next = S_FIN;
      end
      S_FIN: state_next = S_OUT;
      S_OUT: if (out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      present <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (in_ch.valid) begin
          kind <= in_ch.kind;
          key_in <= in_ch.key_value;
          id_in <= in_ch.item_id;
          st <= ST_OK;
          popped <= 1'b0;
        end
        S_RD0: cur <= (kind == KIND_CHANGE) ? pos_rd : slot_t'(0);
        S_RD1: begin
          if (kind == KIND_INSERT) begin
            if (present[id_in]) st <= ST_PRESENT;
            else if (cnt >= cnt_t'(CAPACITY)) st <= ST_FULL;
            else begin
              cur <= slot_t'(cnt); cur_k <= key_in; cur_i <= id_in;
              present[id_in] <= 1'b1;
              cnt <= cnt + cnt_t'(1);
            end
          end else if (kind == KIND_POP) begin
            if (cnt == '0) st <= ST_EMPTY;
          end else if (kind == KIND_CHANGE) begin
            if (!present[id_in]) st <= ST_ABSENT;
          end
        end
        S_DECIDE: begin
          if (kind == KIND_POP) begin
            pop_k <= rk; pop_i <= ri; popped <= 1'b1;
            present[ri] <= 1'b0;
          end else begin
            cur_k <= key_in; cur_i <= id_in;
          end
        end
        S_SWAP2: begin
          cnt <= cnt - cnt_t'(1);
          cur <= '0; cur_k <= rk; cur_i <= ri;
        end
        S_UP_RD: rsl <= (cur - slot_t'(1)) >> 1;
        S_UP_CMP: if (gt) cur <= rsl;
        S_DN_RDR: begin lk <= rk; oth_i <= ri; end
        S_DN_CMP: if (dn_go) cur <= smin_s;
        S_FIN: begin
          ovalid <= 1'b1;
          res.status <= st;
          res.count <= cnt;
          if (popped) begin
            res.has_item <= 1'b1; res.out_key <= 32'(pop_k); res.out_id <= pop_i;
          end else if (cnt != '0) begin
            res.has_item <= 1'b1; res.out_key <= 32'(rk); res.out_id <= ri;
          end else begin
            res.has_item <= 1'b0; res.out_key <= '0; res.out_id <= '0;
          end
        end
        S_OUT: if (out_ch.ready) ovalid <= 1'b0;
        default: ;
      endcase
    end
  end
endmodule

// File: verif/min_heap_priority_queue_test.sv
`timescale 1ns / 1ps
module min_heap_priority_queue_test;
  import mhpq_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  mhpq_in_if in_ch();
  mhpq_out_if out_ch();

  min_heap_priority_queue i_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  typedef struct {
    logic [2:0] status;
    logic has_item;
    logic [31:0] out_key;
    logic [5:0] out_id;
    logic [6:0] count;
  } heap_result_t;

  // predicted heap contents
  key_t heap_key [CAPACITY];
  id_t heap_id [CAPACITY];
  int slot_of [NUM_IDS];
  bit held [NUM_IDS];
  int held_count;

  heap_result_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void swap_slots(input int a, input int b);
    key_t k;
    id_t d;
    k = heap_key[a];
    d = heap_id[a];
    heap_key[a] = heap_key[b];
    heap_id[a] = heap_id[b];
    heap_key[b] = k;
    heap_id[b] = d;
    slot_of[heap_id[a]] = a;
    slot_of[heap_id[b]] = b;
  endfunction

  function automatic void bubble_up(input int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!(heap_key[p] > heap_key[i])) break;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  function automatic void sift_down(input int i);
    int l;
    int r;
    int s;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      if (l >= held_count) break;
      if (r >= held_count) r = l;
      if (!(heap_key[l] < heap_key[i] || heap_key[r] < heap_key[i])) break;
      s = (heap_key[l] <= heap_key[r]) ? l : r;
      swap_slots(i, s);
      i = s;
    end
  endfunction

  function automatic heap_result_t predict_heap_op(input logic [1:0] kind, input key_t k,
                                                   input id_t id);
    heap_result_t res;
    int slot;
    key_t old;
    res = '{default: '0};
    res.status = ST_OK;
    if (kind == KIND_INSERT) begin
      if (held[id]) res.status = ST_PRESENT;
      else if (held_count >= CAPACITY) res.status = ST_FULL;
      else begin
        slot = held_count;
        heap_key[slot] = k;
        heap_id[slot] = id;
        slot_of[id] = slot;
        held[id] = 1'b1;
        held_count++;
        bubble_up(slot);
      end
    end else if (kind == KIND_POP) begin
      if (held_count == 0) res.status = ST_EMPTY;
      else begin
        res.out_key = heap_key[0];
        res.out_id = heap_id[0];
        res.has_item = 1'b1;
        swap_slots(0, held_count - 1);
        held_count--;
        held[res.out_id] = 1'b0;
        if (held_count > 0) sift_down(0);
      end
    end else if (kind == KIND_CHANGE) begin
      if (!held[id]) res.status = ST_ABSENT;
      else begin
        slot = slot_of[id];
        old = heap_key[slot];
        heap_key[slot] = k;
        if (k < old) bubble_up(slot);
        else if (k > old) sift_down(slot);
      end
    end
    if (!res.has_item && held_count > 0) begin
      res.out_key = heap_key[0];
      res.out_id = heap_id[0];
      res.has_item = 1'b1;
    end
    res.count = held_count[6:0];
    return res;
  endfunction

  task automatic send_item(input logic [1:0] kind, input key_t k, input id_t id);
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
    pending_results.push_back(predict_heap_op(kind, k, id));
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.key_value <= k;
    in_ch.item_id <= id;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() > 0) @(negedge clk);
  endtask

  function automatic key_t random_key();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(40)) - 20;
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(2000)) - 1000;
    endcase
  endfunction

  function automatic id_t free_id();
    id_t id;
    id = id_t'($urandom);
    return id;
  endfunction

  // sink side: random stalls, optional long hold-off
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= !(take_idle_pct > 0 && $urandom_range(99) < take_idle_pct);
  end

  always @(posedge clk) begin
    heap_result_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) report_mismatch("result with nothing expected");
      else begin
        e = pending_results.pop_front();
        if (out_ch.status !== e.status)
          report_mismatch($sformatf("status %0d want %0d", out_ch.status, e.status));
        if (out_ch.has_item !== e.has_item)
          report_mismatch($sformatf("has_item %0b want %0b", out_ch.has_item, e.has_item));
        if (out_ch.out_key !== e.out_key)
          report_mismatch($sformatf("out_key %0h want %0h", out_ch.out_key, e.out_key));
        if (out_ch.out_id !== e.out_id)
          report_mismatch($sformatf("out_id %0d want %0d", out_ch.out_id, e.out_id));
        if (out_ch.count !== e.count)
          report_mismatch($sformatf("count %0d want %0d", out_ch.count, e.count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(KIND_POP, 0, 0);
    send_item(KIND_CHANGE, 5, 3);
    send_item(KIND_INSERT, 32'sh7fffffff, 63);
    send_item(KIND_INSERT, 32'sh80000000, 0);
    send_item(KIND_INSERT, 7, 63);
    send_item(KIND_INSERT, 7, 21);
    send_item(KIND_INSERT, 7, 42);
    send_item(KIND_CHANGE, 7, 21);
    send_item(KIND_CHANGE, -5, 42);
    send_item(KIND_CHANGE, 32'sh7fffffff, 0);
    send_item(2'd3, 32'sh5555aaaa, 42);
    send_item(KIND_CHANGE, 1, 9);
    repeat (5) send_item(KIND_POP, 0, 0);
  endtask

  task automatic test_fill_and_full();
    for (int i = 0; i < NUM_IDS; i++) send_item(KIND_INSERT, random_key(), i[5:0]);
    send_item(KIND_INSERT, 1, 5);
    wait_drained();
    // with every id held a full heap only meets held ids; pop one, then insert id 0 again
    send_item(KIND_POP, 0, 0);
    send_item(KIND_INSERT, 32'sh80000000, 0);
    for (int i = 0; i < NUM_IDS; i++) send_item(KIND_CHANGE, random_key(), i[5:0]);
    for (int i = 0; i < NUM_IDS; i++) send_item(KIND_POP, 0, 0);
    send_item(KIND_POP, 0, 0);
  endtask

  task automatic test_random(input int n);
    int op;
    for (int i = 0; i < n; i++) begin
      op = $urandom_range(99);
      if (op < 40 && held_count < 60) send_item(KIND_INSERT, random_key(), free_id());
      else if (op < 40) send_item(KIND_POP, 0, 0);
      else if (op < 65) send_item(KIND_POP, key_t'($urandom), id_t'($urandom));
      else if (op < 97) send_item(KIND_CHANGE, random_key(), free_id());
      else send_item(2'd3, key_t'($urandom), id_t'($urandom));
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 600;
    for (int i = 0; i < 20; i++) send_item(KIND_INSERT, random_key(), free_id());
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_INSERT;
    in_ch.key_value = '0;
    in_ch.item_id = '0;
    held_count = 0;
    foreach (held[i]) held[i] = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    send_idle_pct = 34;
    take_idle_pct = 66;
    test_fill_and_full();
    test_random(350);
    wait_drained();
    send_idle_pct = 66;
    take_idle_pct = 34;
    test_backpressure();
    test_random(350);
    send_idle_pct = 0;
    take_idle_pct = 0;
    test_random(350);
    wait_drained();
    repeat (60) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// File: filelist.f
src/mhpq_pkg.sv
src/mhpq_if.sv
src/mhpq_cmp.sv
src/min_heap_priority_queue.sv
verif/min_heap_priority_queue_test.sv
